/* src/t16dec_pkg.sv */
package t16dec_pkg;

   // Default address width; targets wrap at this width
   localparam int ADDR_WIDTH_DEF = 32;

   localparam int INSTR_W = 16;
   localparam int ADDR_W  = 32;
   localparam int IMM_W   = 32;

   typedef logic [5:0] class_type;

   // Instruction classes (a base is the first of a group)
   localparam class_type CLS_SHIFT_BASE    = 6'd0;
   localparam class_type CLS_ADDSUB_REG    = 6'd3;
   localparam class_type CLS_ADDSUB_IMM3   = 6'd5;
   localparam class_type CLS_IMM8_BASE     = 6'd7;
   localparam class_type CLS_ALU_BASE      = 6'd11;
   localparam class_type CLS_ALU_LAST      = 6'd26;
   localparam class_type CLS_HIREG_BASE    = 6'd27;
   localparam class_type CLS_HIREG_LAST    = 6'd30;
   localparam class_type CLS_PC_LOAD       = 6'd31;
   localparam class_type CLS_REG_LS_BASE   = 6'd32;
   localparam class_type CLS_REG_LS_LAST   = 6'd39;
   localparam class_type CLS_WORD_LS_LAST  = 6'd41;
   localparam class_type CLS_IMM5_LS_BASE  = 6'd40;
   localparam class_type CLS_HALF_LS_BASE  = 6'd44;
   localparam class_type CLS_HALF_LS_LAST  = 6'd45;
   localparam class_type CLS_SP_LS_BASE    = 6'd46;
   localparam class_type CLS_SP_LS_LAST    = 6'd47;
   localparam class_type CLS_ADD_PC        = 6'd48;
   localparam class_type CLS_ADD_SP        = 6'd49;
   localparam class_type CLS_SP_ADJ_BASE   = 6'd50;
   localparam class_type CLS_SP_ADJ_LAST   = 6'd51;
   localparam class_type CLS_PUSH_POP_BASE = 6'd52;
   localparam class_type CLS_PUSH_POP_LAST = 6'd53;
   localparam class_type CLS_LDM_STM_BASE  = 6'd54;
   localparam class_type CLS_LDM_STM_LAST  = 6'd55;
   localparam class_type CLS_SWI           = 6'd56;
   localparam class_type CLS_BCOND         = 6'd57;
   localparam class_type CLS_B             = 6'd58;
   localparam class_type CLS_BL_PREFIX     = 6'd59;
   localparam class_type CLS_BL_SUFFIX     = 6'd60;
   localparam class_type CLS_UNKNOWN       = 6'd61;

   // Register numbers with a fixed role
   localparam logic [3:0] REG_SP = 4'd13;
   localparam logic [3:0] REG_PC = 4'd15;

   // Return encodings of the hi-register group
   localparam logic [15:0] RET_MOV_PC_LR_A = 16'h46b7;
   localparam logic [15:0] RET_MOV_PC_LR_B = 16'h46f7;
   localparam logic [15:0] RET_BX_R6       = 16'h4730;
   localparam logic [15:0] RET_BX_LR       = 16'h4770;

   typedef struct packed {
      logic [INSTR_W-1:0] instr;
      logic [ADDR_W-1:0]  addr;
   } req_type;

   typedef struct packed {
      class_type         op_class;
      logic [3:0]        dest_reg;
      logic [3:0]        src_reg;
      logic [2:0]        second_reg;
      logic [IMM_W-1:0]  immediate;
      logic [3:0]        cond_code;
      logic              is_return;
   } rsp_type;

endpackage

/* src/t16dec_decode.sv */
module t16dec_decode #(
   parameter int ADDR_WIDTH = t16dec_pkg::ADDR_WIDTH_DEF
) (
   input  t16dec_pkg::req_type  req,
   input  logic [ADDR_WIDTH-1:0] link_base,
   output t16dec_pkg::rsp_type  rsp,
   output logic [ADDR_WIDTH-1:0] link_next,
   output logic                 link_load
);
   import t16dec_pkg::*;

   localparam int XW = (ADDR_WIDTH > IMM_W) ? ADDR_WIDTH : IMM_W;

   logic [15:0]            w;
   logic [XW-1:0]          addr_x;
   logic [ADDR_WIDTH-1:0]  pc;
   class_type              cls;
   logic signed [23:0]     off_s;
   logic [ADDR_WIDTH-1:0]  add_a;
   logic [ADDR_WIDTH-1:0]  add_c;
   logic [ADDR_WIDTH-1:0]  target;
   logic [XW-1:0]          target_x;
   logic [10:0]            pc_load_imm;
   logic [2:0]             lo3;
   logic [2:0]             mid3;

   assign w      = req.instr;
   assign addr_x = XW'(req.addr);
   assign pc     = addr_x[ADDR_WIDTH-1:0];
   assign lo3    = w[2:0];
   assign mid3   = w[5:3];

   // Classify by the top three bits, then by the sub-opcode fields
   always_comb begin
      case (w[15:13])
         3'd0: begin
            if (w[12:11] != 2'd3) begin
               cls = CLS_SHIFT_BASE + class_type'(w[12:11]);
            end else if (w[10]) begin
               cls = CLS_ADDSUB_IMM3 + class_type'(w[9]);
            end else begin
               cls = CLS_ADDSUB_REG + class_type'(w[9]);
            end
         end
         3'd1: cls = CLS_IMM8_BASE + class_type'(w[12:11]);
         3'd2: begin
            case (w[12:10])
               3'd0:         cls = CLS_ALU_BASE + class_type'(w[9:6]);
               3'd1:         cls = CLS_HIREG_BASE + class_type'(w[9:8]);
               3'd2, 3'd3:   cls = CLS_PC_LOAD;
               default:      cls = CLS_REG_LS_BASE + class_type'(w[11:9]);
            endcase
         end
         3'd3: cls = CLS_IMM5_LS_BASE + class_type'(w[12:11]);
         3'd4: begin
            if (w[12]) begin
               cls = CLS_SP_LS_BASE + class_type'(w[11]);
            end else begin
               cls = CLS_HALF_LS_BASE + class_type'(w[11]);
            end
         end
         3'd5: begin
            if (!w[12]) begin
               cls = CLS_ADD_PC + class_type'(w[11]);
            end else if (w[11:8] == 4'd0) begin
               cls = CLS_SP_ADJ_BASE + class_type'(w[7]);
            end else begin
               cls = CLS_PUSH_POP_BASE + class_type'(w[11]);
            end
         end
         3'd6: begin
            if (!w[12]) begin
               cls = CLS_LDM_STM_BASE + class_type'(w[11]);
            end else if (w[11:8] == 4'hf) begin
               cls = CLS_SWI;
            end else begin
               cls = CLS_BCOND;
            end
         end
         default: begin
            case (w[12:11])
               2'd0:    cls = CLS_B;
               2'd1:    cls = CLS_UNKNOWN;
               2'd2:    cls = CLS_BL_PREFIX;
               default: cls = CLS_BL_SUFFIX;
            endcase
         end
      endcase
   end

   // Branch offset, already scaled, for the shared target adder
   always_comb begin
      case (cls)
         CLS_BCOND:     off_s = {{15{w[7]}}, w[7:0], 1'b0};
         CLS_B:         off_s = {{12{w[10]}}, w[10:0], 1'b0};
         CLS_BL_PREFIX: off_s = {w[10], w[10:0], 12'd0};
         default:       off_s = {12'd0, w[10:0], 1'b0};
      endcase
   end

   // One adder: pc + offset + 4, or link base + offset for the BL suffix
   assign add_a    = (cls == CLS_BL_SUFFIX) ? link_base : pc;
   assign add_c    = (cls == CLS_BL_SUFFIX) ? '0 : ADDR_WIDTH'(4);
   assign target   = add_a + ADDR_WIDTH'(off_s) + add_c;
   assign target_x = XW'(target);

   // Literal pool offset: 4 * (imm8 + 1), less 2 for a halfword-aligned pc
   assign pc_load_imm = {1'b0, w[7:0], 2'b00} + 11'd4 - ((pc[1:0] != 2'd0) ? 11'd2 : 11'd0);

   assign link_next = target;
   assign link_load = (cls == CLS_BL_PREFIX);

   // Extract fields per class; unused fields stay zero
   always_comb begin
      rsp            = '0;
      rsp.op_class   = cls;
      if (cls < CLS_ADDSUB_REG) begin
         rsp.dest_reg  = {1'b0, lo3};
         rsp.src_reg   = {1'b0, mid3};
         rsp.immediate = IMM_W'(w[10:6]);
      end else if (cls < CLS_ADDSUB_IMM3 ||
                   (cls >= CLS_REG_LS_BASE && cls <= CLS_REG_LS_LAST)) begin
         rsp.dest_reg   = {1'b0, lo3};
         rsp.src_reg    = {1'b0, mid3};
         rsp.second_reg = w[8:6];
      end else if (cls < CLS_IMM8_BASE) begin
         rsp.dest_reg  = {1'b0, lo3};
         rsp.src_reg   = {1'b0, mid3};
         rsp.immediate = IMM_W'(w[8:6]);
      end else if (cls < CLS_ALU_BASE) begin
         rsp.dest_reg  = {1'b0, w[10:8]};
         rsp.immediate = IMM_W'(w[7:0]);
      end else if (cls <= CLS_ALU_LAST) begin
         rsp.dest_reg = {1'b0, lo3};
         rsp.src_reg  = {1'b0, mid3};
      end else if (cls <= CLS_HIREG_LAST) begin
         rsp.dest_reg  = {w[7], lo3};
         rsp.src_reg   = {w[6], mid3};
         rsp.is_return = (w == RET_MOV_PC_LR_A) || (w == RET_MOV_PC_LR_B) ||
                         (w == RET_BX_R6) || (w == RET_BX_LR);
      end else if (cls == CLS_PC_LOAD) begin
         rsp.dest_reg  = {1'b0, w[10:8]};
         rsp.src_reg   = REG_PC;
         rsp.immediate = IMM_W'(pc_load_imm);
      end else if (cls <= CLS_HALF_LS_LAST) begin
         rsp.dest_reg = {1'b0, lo3};
         rsp.src_reg  = {1'b0, mid3};
         if (cls <= CLS_WORD_LS_LAST) begin
            rsp.immediate = IMM_W'({w[10:6], 2'b00});
         end else if (cls >= CLS_HALF_LS_BASE) begin
            rsp.immediate = IMM_W'({w[10:6], 1'b0});
         end else begin
            rsp.immediate = IMM_W'(w[10:6]);
         end
      end else if (cls <= CLS_SP_LS_LAST) begin
         rsp.dest_reg  = {1'b0, w[10:8]};
         rsp.src_reg   = REG_SP;
         rsp.immediate = IMM_W'({w[7:0], 2'b00});
      end else if (cls == CLS_ADD_PC) begin
         rsp.dest_reg  = {1'b0, w[10:8]};
         rsp.src_reg   = REG_PC;
         rsp.immediate = IMM_W'({1'b0, w[7:0], 2'b00}) + IMM_W'(4);
      end else if (cls == CLS_ADD_SP) begin
         rsp.dest_reg  = {1'b0, w[10:8]};
         rsp.src_reg   = REG_SP;
         rsp.immediate = IMM_W'({w[7:0], 2'b00});
      end else if (cls <= CLS_SP_ADJ_LAST) begin
         rsp.dest_reg  = REG_SP;
         rsp.src_reg   = REG_SP;
         rsp.immediate = IMM_W'({w[6:0], 2'b00});
      end else if (cls <= CLS_PUSH_POP_LAST) begin
         rsp.dest_reg  = REG_SP;
         rsp.immediate = IMM_W'(w[7:0]);
      end else if (cls <= CLS_LDM_STM_LAST) begin
         rsp.dest_reg  = {1'b0, w[10:8]};
         rsp.immediate = IMM_W'(w[7:0]);
      end else if (cls == CLS_SWI) begin
         rsp.immediate = IMM_W'(w[7:0]);
      end else if (cls == CLS_BCOND) begin
         rsp.immediate = target_x[IMM_W-1:0];
         rsp.cond_code = w[11:8];
      end else if (cls != CLS_UNKNOWN) begin
         rsp.immediate = target_x[IMM_W-1:0];
      end
   end

endmodule

/* src/thumb16_instruction_decoder_core.sv */
// Thumb-1 instruction decoder. Each transaction on the req_ channel carries one
// 16-bit instruction word and its byte address; the rsp_ channel returns one
// decoded transaction per request, in order: class (61 for unknown), register
// fields, scaled immediate or branch target, condition and return flag. The
// block accepts one request per clock unless rsp_stall holds a full result
// register; a request passes an input register, one pass of field extraction
// with a single target adder, and a result register. A BL prefix leaves its
// partial target in a register that the next BL suffix adds to; reset clears
// it to zero. Branch targets wrap at ADDR_WIDTH bits, returned cut to 32 bits.
module thumb16_instruction_decoder_core #(
   parameter int ADDR_WIDTH = t16dec_pkg::ADDR_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  t16dec_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output t16dec_pkg::rsp_type  rsp_data
);
   import t16dec_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   req_type               in_data_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_data_ff;
   logic [ADDR_WIDTH-1:0] link_base_ff, link_base_in;

   rsp_type               dec_rsp;
   logic [ADDR_WIDTH-1:0] dec_link_next;
   logic                  dec_link_load;
   logic                  accept;
   logic                  advance;

   // Move the held request into the result register when it is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   t16dec_decode #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_decode (
      .req       (in_data_ff),
      .link_base (link_base_ff),
      .rsp       (dec_rsp),
      .link_next (dec_link_next),
      .link_load (dec_link_load)
   );

   // Next valid flags for both stages
   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Update the BL partial target as the prefix leaves decode
   assign link_base_in = (advance && dec_link_load) ? dec_link_next : link_base_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         link_base_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         link_base_ff <= link_base_in;
      end
   end

   // Payload: capture on accept, advance on a free result slot
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= dec_rsp;
      end
   end

endmodule
